// ===== rtl/aot_pkg.sv =====
// Shared types and constants for the alias owner table.
// Depends on nothing; every other file of the block refers to it by scoped names.
package aot_pkg;

    localparam int KEY_W       = 32;
    localparam int OWNER_W     = 16;
    localparam int IN_TDATA_W  = 56;   // owner, alias_req, alias_present, zero fill
    localparam int IN_TUSER_W  = 2;    // kind
    localparam int OUT_TDATA_W = 24;   // status, owner_found, zero fill
    localparam int STATUS_W    = 2;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DISCARD = 2'd1,
        KIND_LOOKUP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NO    = 2'd1,
        ST_FOUND = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EVAL,
        S_COMMIT,
        S_DRAIN
    } t_state;

    // write token that walks down the row of table cells
    typedef struct packed {
        logic               vld;
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
    } t_tok;

    // broadcast controls for the table cells
    typedef struct packed {
        logic cmp;
        logic drop;
    } t_ent_ctrl;

    // one slot of the batch shift line
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
    } t_slot;

    // broadcast controls for the batch cells
    typedef struct packed {
        logic cmp;
        logic shift;
        logic clr;
    } t_bat_ctrl;

endpackage

// ===== rtl/aot_entry_cell.sv =====
// One table entry: key, owner, valid bit, a registered key compare and a token stage.
// Depends on aot_pkg.
module aot_entry_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aot_pkg::t_ent_ctrl           i_ctrl,
    input  logic [aot_pkg::KEY_W-1:0]    i_key,
    input  aot_pkg::t_tok                i_tok,
    output aot_pkg::t_tok                o_tok,
    output logic                         o_hit,
    output logic [aot_pkg::OWNER_W-1:0]  o_owner
);

    logic                        r_vld;
    logic                        r_hit;
    logic [aot_pkg::KEY_W-1:0]   r_key;
    logic [aot_pkg::OWNER_W-1:0] r_owner;
    logic                        r_tok_vld;
    logic [aot_pkg::KEY_W-1:0]   r_tok_key;
    logic [aot_pkg::OWNER_W-1:0] r_tok_owner;
    logic                        w_take;

    // a free cell absorbs the token passing by
    assign w_take = i_tok.vld && !r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_hit     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            if (i_ctrl.cmp) begin
                r_hit <= r_vld && (r_key == i_key);
            end
            if (i_ctrl.drop && r_hit) begin
                r_vld <= 1'b0;
            end else if (w_take) begin
                r_vld <= 1'b1;
            end
            r_tok_vld <= i_tok.vld && r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key   <= i_tok.key;
            r_owner <= i_tok.owner;
        end
        r_tok_key   <= i_tok.key;
        r_tok_owner <= i_tok.owner;
    end

    assign o_tok   = '{vld: r_tok_vld, key: r_tok_key, owner: r_tok_owner};
    assign o_hit   = r_hit;
    assign o_owner = r_hit ? r_owner : '0;

endmodule

// ===== rtl/aot_batch_cell.sv =====
// One slot of the batch key line: holds a gathered key, compares it, shifts toward slot 0.
// Depends on aot_pkg.
module aot_batch_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aot_pkg::t_bat_ctrl         i_ctrl,
    input  logic                       i_ld,
    input  logic [aot_pkg::KEY_W-1:0]  i_key,
    input  aot_pkg::t_slot             i_nxt,
    output aot_pkg::t_slot             o_slot,
    output logic                       o_dup
);

    logic                      r_vld;
    logic                      r_dup;
    logic [aot_pkg::KEY_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_dup <= 1'b0;
        end else begin
            if (i_ctrl.cmp) begin
                r_dup <= r_vld && (r_key == i_key);
            end
            if (i_ctrl.clr) begin
                r_vld <= 1'b0;
            end else if (i_ctrl.shift) begin
                r_vld <= i_nxt.vld;
            end else if (i_ld) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_nxt.key;
        end else if (i_ld) begin
            r_key <= i_key;
        end
    end

    assign o_slot = '{vld: r_vld, key: r_key};
    assign o_dup  = r_dup;

endmodule

// ===== rtl/alias_owner_table_top.sv =====
// Alias owner table top level: control sequencer, row of table cells, batch key line.
// Depends on aot_pkg, aot_entry_cell and aot_batch_cell.
//
//  channel  | dir | handshake                | payload (lowest bit first)
//  ---------+-----+--------------------------+--------------------------------------------
//  request  | in  | i_s_tvalid / o_s_tready  | tdata: owner, alias_req, alias_present, 0s
//           |     |                          | tuser: kind   tlast: batch_last
//  response | out | o_m_tvalid / i_m_tready  | tdata: status, owner_found, 0s
//
//  Sequence: every beat goes latch, compare in all cells, evaluate, from accept
//  to the next accept; the evaluate step also waits on i_m_tready while a held
//  response blocks it. A committed insert batch then feeds its keys into the
//  cell row, and the drain state holds until the last write token has walked
//  the full row, since tokens move one cell per cycle.
//  Reset: synchronous, active low; valid bits in every cell clear at once, so no
//  clearing pass is needed. Stalls: a held response only blocks the sequencer
//  when a new response is due; the request side is taken as soon as it is idle.
module alias_owner_table_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int BATCH_MAX     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [aot_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // owner, alias_req, alias_present
    input  logic [aot_pkg::IN_TUSER_W-1:0]     i_s_tuser,  // kind
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [aot_pkg::OUT_TDATA_W-1:0]    o_m_tdata   // status, owner_found
);

    localparam int FW = $clog2(TABLE_ENTRIES + 1);   // free entry count
    localparam int CW = $clog2(BATCH_MAX + 1);       // gathered key count
    localparam int MW = (FW > CW) ? FW : CW;
    localparam int DW = $clog2(TABLE_ENTRIES);       // drain counter
    localparam int KW = aot_pkg::KEY_W;
    localparam int OW = aot_pkg::OWNER_W;

    // sequencer and batch state
    aot_pkg::t_state          r_state, n_state;
    logic [FW-1:0]            r_free, n_free;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_conflict, n_conflict;
    logic                     r_overflow, n_overflow;
    logic [DW-1:0]            r_drain, n_drain;

    // latched request beat
    logic [1:0]               r_kind;
    logic [OW-1:0]            r_owner;
    logic [KW-1:0]            r_key;
    logic                     r_present;
    logic                     r_last;

    // response register
    logic                     r_out_vld, n_out_vld;
    aot_pkg::t_status         r_status, n_status;
    logic [OW-1:0]            r_found, n_found;

    logic                     w_s_acc;
    logic                     w_out_free;
    aot_pkg::t_ent_ctrl       w_ent_ctrl;
    aot_pkg::t_bat_ctrl       w_bat_ctrl;
    logic                     w_store_go;
    aot_pkg::t_tok            w_tok [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [OW-1:0]            w_own [0:TABLE_ENTRIES-1];
    logic [OW-1:0]            w_own_or;
    logic                     w_any_hit;
    aot_pkg::t_slot           w_slot [0:BATCH_MAX];
    logic [BATCH_MAX-1:0]     w_bdup;
    logic [BATCH_MAX-1:0]     w_bld;
    logic                     w_dup;
    logic                     w_new_key;
    logic                     w_bat_full;
    logic                     w_store;
    logic                     w_e_conflict;
    logic                     w_e_overflow;
    logic [CW-1:0]            w_e_count;
    aot_pkg::t_status         w_ins_status;

    assign o_s_tready = i_rst_n && (r_state == aot_pkg::S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;

    // latch the request beat
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_kind    <= i_s_tuser[1:0];
            r_owner   <= i_s_tdata[15:0];
            r_key     <= i_s_tdata[47:16];
            r_present <= i_s_tdata[48];
            r_last    <= i_s_tlast;
        end
    end

    // table cell row: compare broadcast, write tokens enter at cell 0
    assign w_tok[0] = '{vld:   (r_state == aot_pkg::S_COMMIT),
                        key:   w_slot[0].key,
                        owner: r_owner};

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ent
        aot_entry_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ent_ctrl),
            .i_key   (r_key),
            .i_tok   (w_tok[gi]),
            .o_tok   (w_tok[gi+1]),
            .o_hit   (w_hit[gi]),
            .o_owner (w_own[gi])
        );
    end

    // keys are unique in the table, so at most one cell drives a nonzero owner
    always_comb begin
        w_own_or = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_own_or = w_own_or | w_own[i];
        end
    end
    assign w_any_hit = |w_hit;

    // batch key line: loads at slot r_count, shifts toward slot 0 on commit
    assign w_slot[BATCH_MAX] = '{vld: 1'b0, key: '0};

    for (genvar gk = 0; gk < BATCH_MAX; gk++) begin : g_bat
        assign w_bld[gk] = w_store_go && (r_count == CW'(gk));
        aot_batch_cell u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_bat_ctrl),
            .i_ld    (w_bld[gk]),
            .i_key   (r_key),
            .i_nxt   (w_slot[gk+1]),
            .o_slot  (w_slot[gk]),
            .o_dup   (w_bdup[gk])
        );
    end
    assign w_dup = |w_bdup;

    // insert element evaluation
    assign w_new_key    = r_present && !w_dup;
    assign w_bat_full   = (r_count == CW'(BATCH_MAX));
    assign w_store      = (r_kind == aot_pkg::KIND_INSERT) && w_new_key && !w_bat_full;
    assign w_e_conflict = r_conflict || (r_present && w_any_hit);
    assign w_e_overflow = r_overflow || (w_new_key && w_bat_full);
    assign w_e_count    = r_count + CW'(w_store);

    always_comb begin
        if (w_e_conflict) begin
            w_ins_status = aot_pkg::ST_NO;
        end else if (w_e_overflow) begin
            w_ins_status = aot_pkg::ST_FULL;
        end else if (MW'(r_free) < MW'(w_e_count)) begin
            w_ins_status = aot_pkg::ST_FULL;
        end else begin
            w_ins_status = aot_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aot_pkg::S_IDLE;
            r_free     <= FW'(TABLE_ENTRIES);
            r_count    <= '0;
            r_conflict <= 1'b0;
            r_overflow <= 1'b0;
            r_drain    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free     <= n_free;
            r_count    <= n_count;
            r_conflict <= n_conflict;
            r_overflow <= n_overflow;
            r_drain    <= n_drain;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_count    = r_count;
        n_conflict = r_conflict;
        n_overflow = r_overflow;
        n_drain    = r_drain;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_status   = r_status;
        n_found    = r_found;
        w_ent_ctrl = '{cmp: 1'b0, drop: 1'b0};
        w_bat_ctrl = '{cmp: 1'b0, shift: 1'b0, clr: 1'b0};
        w_store_go = 1'b0;

        case (r_state)
            aot_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_state = aot_pkg::S_CMP;
                end
            end

            aot_pkg::S_CMP: begin
                w_ent_ctrl.cmp = 1'b1;
                w_bat_ctrl.cmp = 1'b1;
                n_state        = aot_pkg::S_EVAL;
            end

            aot_pkg::S_EVAL: begin
                case (r_kind)
                    aot_pkg::KIND_INSERT: begin
                        if (!r_last) begin
                            // gather only; no response
                            w_store_go = w_store;
                            n_conflict = w_e_conflict;
                            n_overflow = w_e_overflow;
                            n_count    = w_e_count;
                            n_state    = aot_pkg::S_IDLE;
                        end else if (w_out_free) begin
                            w_store_go = w_store;
                            n_out_vld  = 1'b1;
                            n_status   = w_ins_status;
                            n_found    = '0;
                            n_conflict = 1'b0;
                            n_overflow = 1'b0;
                            if ((w_ins_status == aot_pkg::ST_OK) && (w_e_count != '0)) begin
                                // reserve the entries, then feed keys into the row
                                n_count = w_e_count;
                                n_free  = r_free - FW'(w_e_count);
                                n_state = aot_pkg::S_COMMIT;
                            end else begin
                                n_count        = '0;
                                w_bat_ctrl.clr = 1'b1;
                                n_state        = aot_pkg::S_IDLE;
                            end
                        end
                    end
                    aot_pkg::KIND_DISCARD: begin
                        if (w_out_free) begin
                            n_out_vld       = 1'b1;
                            n_found         = '0;
                            w_ent_ctrl.drop = 1'b1;
                            if (w_any_hit) begin
                                n_status = aot_pkg::ST_OK;
                                n_free   = r_free + FW'(1);
                            end else begin
                                n_status = aot_pkg::ST_NO;
                            end
                            n_state = aot_pkg::S_IDLE;
                        end
                    end
                    aot_pkg::KIND_LOOKUP: begin
                        if (w_out_free) begin
                            n_out_vld = 1'b1;
                            n_status  = w_any_hit ? aot_pkg::ST_FOUND : aot_pkg::ST_NO;
                            n_found   = w_any_hit ? w_own_or : '0;
                            n_state   = aot_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        // unused kind: drop the beat
                        n_state = aot_pkg::S_IDLE;
                    end
                endcase
            end

            aot_pkg::S_COMMIT: begin
                // slot 0 enters the row as a token; advance the line
                w_bat_ctrl.shift = 1'b1;
                n_count          = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_drain = DW'(TABLE_ENTRIES - 1);
                    n_state = aot_pkg::S_DRAIN;
                end
            end

            aot_pkg::S_DRAIN: begin
                // hold until the last token has walked the whole row
                if ((r_drain == '0) && !w_tok[TABLE_ENTRIES].vld) begin
                    n_state = aot_pkg::S_IDLE;
                end else if (r_drain != '0) begin
                    n_drain = r_drain - DW'(1);
                end
            end

            default: begin
                n_state = aot_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(aot_pkg::OUT_TDATA_W - aot_pkg::STATUS_W - OW){1'b0}},
                         r_found, r_status};

endmodule

// ===== rtl/aot_checker.sv =====
// Port-level checks for the alias owner table, bound to the top level.
// Depends on aot_pkg and alias_owner_table_top.
module aot_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [aot_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic [aot_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [aot_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled response beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("response changed while stalled");

    // owner field and fill bits are zero unless a lookup hit
    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != aot_pkg::ST_FOUND) |-> (o_m_tdata[23:2] == '0))
        else $error("owner_found set without found status");

    // one request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    // a fresh response follows an accepted request
    a_resp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 3))
        else $error("response without a matching request");

endmodule

bind alias_owner_table_top aot_checker u_aot_checker (.*);
